/* design/mtxwq_pkg.sv */
package mtxwq_pkg;

   // field widths
   localparam int CMD_W  = 2;
   localparam int NUM_W  = 32;
   localparam int PID_W  = 31;
   localparam int STAT_W = 3;

   // defaults for the top-level parameters
   localparam int DEF_MUTEX_SLOTS = 16;
   localparam int DEF_WAIT_DEPTH  = 8;

   // most wake results reported for one remove-process command
   localparam int RESULT_CAP = 16;

   // request commands
   localparam logic [CMD_W-1:0] CMD_LOCK   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_UNLOCK = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RMPROC = 2'd2;
   localparam logic [CMD_W-1:0] CMD_RMSIG  = 2'd3;

   // result status codes
   localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
   localparam logic [STAT_W-1:0] ST_HELD     = 3'd1;
   localparam logic [STAT_W-1:0] ST_QUEUED   = 3'd2;
   localparam logic [STAT_W-1:0] ST_EPERM    = 3'd3;
   localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;
   localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd5;

   // datapath micro-operations
   localparam int OP_W = 5;
   localparam logic [OP_W-1:0] OP_NONE     = 5'd0;
   localparam logic [OP_W-1:0] OP_LOAD     = 5'd1;
   localparam logic [OP_W-1:0] OP_RD_NUM   = 5'd2;
   localparam logic [OP_W-1:0] OP_CMP_NUM  = 5'd3;
   localparam logic [OP_W-1:0] OP_SEL_HIT  = 5'd4;
   localparam logic [OP_W-1:0] OP_BIND     = 5'd5;
   localparam logic [OP_W-1:0] OP_TAKE     = 5'd6;
   localparam logic [OP_W-1:0] OP_ENQ      = 5'd7;
   localparam logic [OP_W-1:0] OP_RELEASE  = 5'd8;
   localparam logic [OP_W-1:0] OP_RD_HEAD  = 5'd9;
   localparam logic [OP_W-1:0] OP_SET_HEAD = 5'd10;
   localparam logic [OP_W-1:0] OP_RD_NEXT  = 5'd11;
   localparam logic [OP_W-1:0] OP_SHIFT    = 5'd12;
   localparam logic [OP_W-1:0] OP_DEC      = 5'd13;
   localparam logic [OP_W-1:0] OP_RD_Q     = 5'd14;
   localparam logic [OP_W-1:0] OP_K_INC    = 5'd15;
   localparam logic [OP_W-1:0] OP_MARK     = 5'd16;
   localparam logic [OP_W-1:0] OP_RD_HOLD  = 5'd17;
   localparam logic [OP_W-1:0] OP_NEXT     = 5'd18;

   // result word selection
   localparam logic [1:0] EM_PLAIN = 2'd0;
   localparam logic [1:0] EM_WAKE  = 2'd1;
   localparam logic [1:0] EM_FINAL = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic              grant;
      logic              emit;
      logic [1:0]        emit_sel;
      logic [STAT_W-1:0] status;
   } dp_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             hit;
      logic             free_v;
      logic             held_s;
      logic             hold_eq;
      logic             wq_eq;
      logic             cnt_full;
      logic             cnt_zero;
      logic             k_lt;
      logic             j_more;
      logic             s_last;
   } dp_stat_type;

endpackage

/* design/mtxwq_dp.sv */
module mtxwq_dp #(
   parameter int MUTEX_SLOTS = mtxwq_pkg::DEF_MUTEX_SLOTS,
   parameter int WAIT_DEPTH  = mtxwq_pkg::DEF_WAIT_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mtxwq_pkg::dp_cmd_type               ctl,
   input  logic [mtxwq_pkg::CMD_W-1:0]         req_cmd,
   input  logic signed [mtxwq_pkg::NUM_W-1:0]  req_mutex_id,
   input  logic [mtxwq_pkg::PID_W-1:0]         req_process_id,
   output mtxwq_pkg::dp_stat_type              stat,
   output logic                                rsp_valid,
   output logic [mtxwq_pkg::STAT_W-1:0]        rsp_status,
   output logic                                rsp_wake_valid,
   output logic [mtxwq_pkg::PID_W-1:0]         rsp_wake_process,
   output logic                                rsp_last
);
   import mtxwq_pkg::*;

   localparam int SW = $clog2(MUTEX_SLOTS);
   localparam int CW = $clog2(WAIT_DEPTH + 1);
   localparam int QN = MUTEX_SLOTS * WAIT_DEPTH;
   localparam int AW = $clog2(QN);
   localparam int NW = $clog2(RESULT_CAP + 1);

   // captured request word
   logic [CMD_W-1:0] cmd_ff;
   logic [NUM_W-1:0] num_ff;
   logic [PID_W-1:0] who_ff;

   // scan indexes and search results
   logic [SW-1:0] s_ff;
   logic [CW-1:0] k_ff;
   logic [CW-1:0] j_ff;
   logic          hit_ff;
   logic [SW-1:0] hit_s_ff;
   logic          free_v_ff;
   logic [SW-1:0] free_s_ff;
   logic [PID_W-1:0] head_ff;

   // held-back grant word of remove-process
   logic             pend_v_ff;
   logic [PID_W-1:0] pend_pid_ff;
   logic [NW-1:0]    n_ff;

   // per-slot flags
   logic          bound_ff [MUTEX_SLOTS];
   logic          held_ff  [MUTEX_SLOTS];
   logic [CW-1:0] cnt_ff   [MUTEX_SLOTS];

   // memories and their registered read data
   logic [NUM_W-1:0] num_mem  [MUTEX_SLOTS];
   logic [PID_W-1:0] hold_mem [MUTEX_SLOTS];
   logic [PID_W-1:0] wq_mem   [QN];
   logic [NUM_W-1:0] num_q;
   logic [PID_W-1:0] hold_q;
   logic [PID_W-1:0] wq_q;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic              rsp_wv_ff, rsp_wv_in;
   logic [PID_W-1:0]  rsp_wp_ff, rsp_wp_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [AW-1:0] q_base;
   logic [CW:0]   j_nx;
   logic [AW-1:0] wq_raddr;
   logic [AW-1:0] wq_waddr;
   logic [SW-1:0] hold_raddr;
   logic          s_last;
   logic          grant_ok;

   // address generation
   assign q_base = AW'(s_ff) * AW'(WAIT_DEPTH);
   assign j_nx   = {1'b0, j_ff} + (CW+1)'(1);
   assign s_last = (s_ff == SW'(MUTEX_SLOTS - 1));
   assign grant_ok = ctl.grant && (n_ff < NW'(RESULT_CAP));
   assign hold_raddr = (ctl.op == OP_SEL_HIT) ? hit_s_ff : s_ff;
   assign wq_waddr = (ctl.op == OP_ENQ) ? q_base + AW'(cnt_ff[s_ff]) : q_base + AW'(j_ff);

   always_comb begin
      case (ctl.op)
         OP_RD_HEAD: wq_raddr = q_base;
         OP_RD_NEXT: wq_raddr = q_base + AW'(j_nx);
         default:    wq_raddr = q_base + AW'(k_ff);
      endcase
   end

   // status back to the controller
   always_comb begin
      stat.cmd      = cmd_ff;
      stat.hit      = hit_ff;
      stat.free_v   = free_v_ff;
      stat.held_s   = held_ff[s_ff];
      stat.hold_eq  = (hold_q == who_ff);
      stat.wq_eq    = (wq_q == who_ff);
      stat.cnt_full = (cnt_ff[s_ff] >= CW'(WAIT_DEPTH));
      stat.cnt_zero = (cnt_ff[s_ff] == '0);
      stat.k_lt     = (k_ff < cnt_ff[s_ff]);
      stat.j_more   = (j_nx < {1'b0, cnt_ff[s_ff]});
      stat.s_last   = s_last;
   end

   // indexes, flags and counts
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MUTEX_SLOTS; i++) begin
            bound_ff[i] <= 1'b0;
            held_ff[i]  <= 1'b0;
            cnt_ff[i]   <= '0;
         end
         pend_v_ff <= 1'b0;
         n_ff      <= '0;
         hit_ff    <= 1'b0;
         free_v_ff <= 1'b0;
      end else begin
         unique case (ctl.op)
            OP_LOAD: begin
               cmd_ff    <= req_cmd;
               num_ff    <= req_mutex_id;
               who_ff    <= req_process_id;
               s_ff      <= '0;
               k_ff      <= '0;
               hit_ff    <= 1'b0;
               free_v_ff <= 1'b0;
               pend_v_ff <= 1'b0;
               n_ff      <= '0;
            end
            OP_CMP_NUM: begin
               if (bound_ff[s_ff] && (num_q == num_ff) && !hit_ff) begin
                  hit_ff   <= 1'b1;
                  hit_s_ff <= s_ff;
               end
               if (!held_ff[s_ff] && !free_v_ff) begin
                  free_v_ff <= 1'b1;
                  free_s_ff <= s_ff;
               end
               if (!s_last) s_ff <= s_ff + 1'b1;
            end
            OP_SEL_HIT: s_ff <= hit_s_ff;
            OP_BIND: begin
               bound_ff[free_s_ff] <= 1'b1;
               held_ff[free_s_ff]  <= 1'b1;
               cnt_ff[free_s_ff]   <= '0;
            end
            OP_TAKE:     held_ff[s_ff] <= 1'b1;
            OP_ENQ:      cnt_ff[s_ff] <= cnt_ff[s_ff] + 1'b1;
            OP_RELEASE:  held_ff[s_ff] <= 1'b0;
            OP_RD_HEAD:  j_ff <= '0;
            OP_SET_HEAD: head_ff <= wq_q;
            OP_SHIFT:    j_ff <= j_ff + 1'b1;
            OP_DEC:      cnt_ff[s_ff] <= cnt_ff[s_ff] - 1'b1;
            OP_K_INC:    k_ff <= k_ff + 1'b1;
            OP_MARK:     j_ff <= k_ff;
            OP_NEXT: begin
               s_ff <= s_ff + 1'b1;
               k_ff <= '0;
            end
            default: ;
         endcase
         // record a grant; the previous one goes out with last low
         if (grant_ok) begin
            pend_v_ff   <= 1'b1;
            pend_pid_ff <= head_ff;
            n_ff        <= n_ff + 1'b1;
         end
      end
   end

   // slot number memory
   always_ff @(posedge clock) begin
      if (ctl.op == OP_BIND) num_mem[free_s_ff] <= num_ff;
      num_q <= num_mem[s_ff];
   end

   // holder memory
   always_ff @(posedge clock) begin
      if (ctl.op == OP_BIND) hold_mem[free_s_ff] <= who_ff;
      else if (ctl.op == OP_TAKE) hold_mem[s_ff] <= who_ff;
      else if (ctl.op == OP_SET_HEAD) hold_mem[s_ff] <= wq_q;
      hold_q <= hold_mem[hold_raddr];
   end

   // waiter memory
   always_ff @(posedge clock) begin
      if (ctl.op == OP_ENQ) wq_mem[wq_waddr] <= who_ff;
      else if (ctl.op == OP_SHIFT) wq_mem[wq_waddr] <= wq_q;
      wq_q <= wq_mem[wq_raddr];
   end

   // result word select
   always_comb begin
      rsp_valid_in  = 1'b0;
      rsp_status_in = ST_OK;
      rsp_wv_in     = 1'b0;
      rsp_wp_in     = '0;
      rsp_last_in   = 1'b1;
      if (ctl.emit) begin
         rsp_valid_in = 1'b1;
         case (ctl.emit_sel)
            EM_PLAIN: rsp_status_in = ctl.status;
            EM_WAKE: begin
               rsp_wv_in = 1'b1;
               rsp_wp_in = head_ff;
            end
            EM_FINAL: begin
               rsp_wv_in = pend_v_ff;
               rsp_wp_in = pend_v_ff ? pend_pid_ff : '0;
            end
            default: ;
         endcase
      end else if (grant_ok && pend_v_ff) begin
         rsp_valid_in = 1'b1;
         rsp_wv_in    = 1'b1;
         rsp_wp_in    = pend_pid_ff;
         rsp_last_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_wv_ff     <= rsp_wv_in;
      rsp_wp_ff     <= rsp_wp_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_wake_valid   = rsp_wv_ff;
   assign rsp_wake_process = rsp_wp_ff;
   assign rsp_last         = rsp_last_ff;

`ifndef SYNTHESIS
   // a word without a wake carries no process
   a_no_wake_pid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_wake_valid |-> rsp_wake_process == '0)
      else $error("wake process set without wake");
   // only success words can precede others of the same request
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_last)
      else $error("error status not on final word");
   // controller never enqueues on a full queue
   a_enq_room: assert property (@(posedge clock) disable iff (reset)
      ctl.op == OP_ENQ |-> cnt_ff[s_ff] < CW'(WAIT_DEPTH))
      else $error("enqueue on full queue");
   // a shift only moves entries inside the live part of the queue
   a_shift_range: assert property (@(posedge clock) disable iff (reset)
      ctl.op == OP_SHIFT |-> {1'b0, j_ff} < {1'b0, cnt_ff[s_ff]})
      else $error("shift beyond queue");
`endif

endmodule

/* design/mtxwq_ctrl.sv */
module mtxwq_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [mtxwq_pkg::CMD_W-1:0] req_cmd,
   input  mtxwq_pkg::dp_stat_type      stat,
   output mtxwq_pkg::dp_cmd_type       ctl,
   output logic                        busy
);
   import mtxwq_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_FRD  = 4'd1;
   localparam logic [3:0] S_FCMP = 4'd2;
   localparam logic [3:0] S_FEND = 4'd3;
   localparam logic [3:0] S_FDEC = 4'd4;
   localparam logic [3:0] S_PRD  = 4'd5;
   localparam logic [3:0] S_PHD  = 4'd6;
   localparam logic [3:0] S_DTST = 4'd7;
   localparam logic [3:0] S_DWR  = 4'd8;
   localparam logic [3:0] S_QTST = 4'd9;
   localparam logic [3:0] S_QCMP = 4'd10;
   localparam logic [3:0] S_HRD  = 4'd11;
   localparam logic [3:0] S_HCMP = 4'd12;
   localparam logic [3:0] S_NX   = 4'd13;

   logic [3:0] state_ff, state_in;
   logic       ret_pop_ff, ret_pop_in;

   // next state and datapath command
   always_comb begin
      state_in     = state_ff;
      ret_pop_in   = ret_pop_ff;
      ctl.op       = OP_NONE;
      ctl.grant    = 1'b0;
      ctl.emit     = 1'b0;
      ctl.emit_sel = EM_PLAIN;
      ctl.status   = ST_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl.op = OP_LOAD;
               if (req_cmd == CMD_LOCK || req_cmd == CMD_UNLOCK) state_in = S_FRD;
               else state_in = S_QTST;
            end
         end
         S_FRD: begin
            ctl.op   = OP_RD_NUM;
            state_in = S_FCMP;
         end
         S_FCMP: begin
            ctl.op   = OP_CMP_NUM;
            state_in = stat.s_last ? S_FEND : S_FRD;
         end
         S_FEND: begin
            ctl.op   = OP_SEL_HIT;
            state_in = S_FDEC;
         end
         S_FDEC: begin
            ctl.emit = 1'b1;
            state_in = S_IDLE;
            if (stat.cmd == CMD_LOCK) begin
               if (!stat.hit) begin
                  if (!stat.free_v) ctl.status = ST_FULL;
                  else ctl.op = OP_BIND;
               end else if (!stat.held_s) begin
                  ctl.op = OP_TAKE;
               end else if (stat.hold_eq) begin
                  ctl.status = ST_HELD;
               end else if (stat.cnt_full) begin
                  ctl.status = ST_FULL;
               end else begin
                  ctl.op     = OP_ENQ;
                  ctl.status = ST_QUEUED;
               end
            end else begin
               if (!stat.hit || !stat.held_s || !stat.hold_eq) begin
                  ctl.status = ST_EPERM;
               end else if (stat.cnt_zero) begin
                  ctl.op = OP_RELEASE;
               end else begin
                  ctl.emit   = 1'b0;
                  ret_pop_in = 1'b1;
                  state_in   = S_PRD;
               end
            end
         end
         // pop the head waiter into the holder
         S_PRD: begin
            ctl.op   = OP_RD_HEAD;
            state_in = S_PHD;
         end
         S_PHD: begin
            ctl.op   = OP_SET_HEAD;
            state_in = S_DTST;
         end
         // close the gap at position j
         S_DTST: begin
            if (stat.j_more) begin
               ctl.op   = OP_RD_NEXT;
               state_in = S_DWR;
            end else begin
               ctl.op = OP_DEC;
               if (ret_pop_ff) begin
                  if (stat.cmd == CMD_UNLOCK) begin
                     ctl.emit     = 1'b1;
                     ctl.emit_sel = EM_WAKE;
                     state_in     = S_IDLE;
                  end else begin
                     ctl.grant = 1'b1;
                     state_in  = S_NX;
                  end
               end else if (stat.cmd == CMD_RMSIG) begin
                  ctl.emit = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_QTST;
               end
            end
         end
         S_DWR: begin
            ctl.op   = OP_SHIFT;
            state_in = S_DTST;
         end
         // walk the queue of the current slot
         S_QTST: begin
            if (stat.k_lt) begin
               ctl.op   = OP_RD_Q;
               state_in = S_QCMP;
            end else begin
               state_in = (stat.cmd == CMD_RMPROC) ? S_HRD : S_NX;
            end
         end
         S_QCMP: begin
            if (stat.wq_eq) begin
               ctl.op     = OP_MARK;
               ret_pop_in = 1'b0;
               state_in   = S_DTST;
            end else begin
               ctl.op   = OP_K_INC;
               state_in = S_QTST;
            end
         end
         // release what the removed process holds
         S_HRD: begin
            if (stat.held_s) begin
               ctl.op   = OP_RD_HOLD;
               state_in = S_HCMP;
            end else begin
               state_in = S_NX;
            end
         end
         S_HCMP: begin
            if (!stat.hold_eq) begin
               state_in = S_NX;
            end else if (stat.cnt_zero) begin
               ctl.op   = OP_RELEASE;
               state_in = S_NX;
            end else begin
               ret_pop_in = 1'b1;
               state_in   = S_PRD;
            end
         end
         S_NX: begin
            if (stat.s_last) begin
               ctl.emit = 1'b1;
               state_in = S_IDLE;
               if (stat.cmd == CMD_RMPROC) ctl.emit_sel = EM_FINAL;
               else ctl.status = ST_NOTFOUND;
            end else begin
               ctl.op   = OP_NEXT;
               state_in = S_QTST;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         ret_pop_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         ret_pop_ff <= ret_pop_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

/* design/mutex_table_with_fifo_waiters_core.sv */
// channel   ports                                   handshake
// request   req_cmd, req_mutex_id, req_process_id  start && !busy
// result    rsp_status, rsp_wake_valid,             rsp_valid, one cycle
//           rsp_wake_process, rsp_last
//
// Lock and unlock scan the slot numbers, reading and comparing one slot at
// a time; an unlock with waiters then pops the head and moves each waiter up.
// Remove commands walk the queues through the waiter memory, reading and
// comparing one entry at a time; a delete shifts the later entries up.
// Reset is synchronous; it clears the bound, held and count flags at once.
// start is ignored while busy; results cannot be held off by the receiver.
module mutex_table_with_fifo_waiters_core #(
   parameter int MUTEX_SLOTS = mtxwq_pkg::DEF_MUTEX_SLOTS,
   parameter int WAIT_DEPTH  = mtxwq_pkg::DEF_WAIT_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [mtxwq_pkg::CMD_W-1:0]         req_cmd,
   input  logic signed [mtxwq_pkg::NUM_W-1:0]  req_mutex_id,
   input  logic [mtxwq_pkg::PID_W-1:0]         req_process_id,
   output logic                                rsp_valid,
   output logic [mtxwq_pkg::STAT_W-1:0]        rsp_status,
   output logic                                rsp_wake_valid,
   output logic [mtxwq_pkg::PID_W-1:0]         rsp_wake_process,
   output logic                                rsp_last
);
   import mtxwq_pkg::*;

   dp_cmd_type  ctl;
   dp_stat_type stat;

   // sequencer
   mtxwq_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_cmd),
      .stat    (stat),
      .ctl     (ctl),
      .busy    (busy)
   );

   // tables, queues and result register
   mtxwq_dp #(
      .MUTEX_SLOTS (MUTEX_SLOTS),
      .WAIT_DEPTH  (WAIT_DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .req_cmd          (req_cmd),
      .req_mutex_id     (req_mutex_id),
      .req_process_id   (req_process_id),
      .stat             (stat),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_wake_valid   (rsp_wake_valid),
      .rsp_wake_process (rsp_wake_process),
      .rsp_last         (rsp_last)
   );

endmodule
